>>> src/assert_macros.svh
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent on the same edge
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/tvac_pkg.sv
// shared types and constants of the valve actuator controller
`timescale 1ns / 1ps
`default_nettype none

package tvac_pkg;

  // width of the wrapping phase timer
  localparam int unsigned TIME_WIDTH = 32;
  typedef logic [TIME_WIDTH-1:0] time_t;

  // configuration port geometry
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_PREBOOT_WAIT = 2'd0,
    REG_BOOT_HOLD    = 2'd1,
    REG_RELAY_RUN    = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  localparam logic [15:0] PREBOOT_WAIT_RST = 16'd500;
  localparam logic [15:0] BOOT_HOLD_RST    = 16'd5000;
  localparam logic [15:0] RELAY_RUN_RST    = 16'd6000;

  typedef struct packed {
    logic [15:0] preboot_wait_ms;
    logic [15:0] boot_hold_ms;
    logic [15:0] relay_run_ms;
  } cfg_t;

  // led pattern selection
  typedef enum logic [1:0] {
    LED_BREATHE_SLOW = 2'd0,
    LED_BREATHE_FAST = 2'd1,
    LED_BLINK_FAST   = 2'd2,
    LED_BLINK_SLOW   = 2'd3
  } led_mode_t;

  localparam logic [9:0] LED_BOOT_LEVEL  = 10'd256;
  localparam logic [9:0] LED_BLINK_LEVEL = 10'd512;

  // floor(x / 125) = (x * RECIP_125) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_125   = 32'h1062_4DD3;
  localparam int unsigned RECIP_SHIFT = 35;

endpackage

`default_nettype wire

>>> src/tvac_in_if.sv
// input channel: one millisecond tick word
`timescale 1ns / 1ps
`default_nettype none

interface tvac_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        close_pressed;
  logic        open_pressed;
  logic        remote_open;
  logic        remote_close;

  modport source (
    output valid, now_ms, close_pressed, open_pressed, remote_open, remote_close,
    input  ready
  );

  modport sink (
    input  valid, now_ms, close_pressed, open_pressed, remote_open, remote_close,
    output ready
  );
endinterface

`default_nettype wire

>>> src/tvac_out_if.sv
// result channel: relay, led and indicator word
`timescale 1ns / 1ps
`default_nettype none

interface tvac_out_if;
  logic       valid;
  logic       ready;
  logic       open_relay;
  logic       close_relay;
  logic [9:0] led_level;
  logic       status_indicator;
  logic       open_indicator;
  logic       close_indicator;
  logic       setup_request;
  logic [2:0] valve_state;

  modport source (
    output valid, open_relay, close_relay, led_level, status_indicator,
           open_indicator, close_indicator, setup_request, valve_state,
    input  ready
  );

  modport sink (
    input  valid, open_relay, close_relay, led_level, status_indicator,
           open_indicator, close_indicator, setup_request, valve_state,
    output ready
  );
endinterface

`default_nettype wire

>>> src/tvac_cfg_regs.sv
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none

module tvac_cfg_regs
  import tvac_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register write in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preboot_wait_ms <= PREBOOT_WAIT_RST;
      cfg_r.boot_hold_ms    <= BOOT_HOLD_RST;
      cfg_r.relay_run_ms    <= RELAY_RUN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PREBOOT_WAIT: cfg_r.preboot_wait_ms <= pwdata[15:0];
        REG_BOOT_HOLD:    cfg_r.boot_hold_ms    <= pwdata[15:0];
        REG_RELAY_RUN:    cfg_r.relay_run_ms    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_PREBOOT_WAIT: prdata = CFG_DATA_W'(cfg_r.preboot_wait_ms);
      REG_BOOT_HOLD:    prdata = CFG_DATA_W'(cfg_r.boot_hold_ms);
      REG_RELAY_RUN:    prdata = CFG_DATA_W'(cfg_r.relay_run_ms);
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> src/tvac_led.sv
// status led pattern generator: breathing ramps and blink rates
`timescale 1ns / 1ps
`default_nettype none

module tvac_led
  import tvac_pkg::*;
(
  input  wire logic [31:0] now,
  input  wire led_mode_t   mode,
  output logic      [9:0]  led
);

  logic [31:0] dividend;
  logic [63:0] prod;
  logic        blink;

  // divide by 125, or by 250 as a halved dividend
  assign dividend = (mode == LED_BLINK_SLOW) ? {1'b0, now[31:1]} : now;
  assign prod     = 64'(dividend) * 64'(RECIP_125);
  assign blink    = prod[RECIP_SHIFT];

  // pattern select
  always_comb begin
    case (mode)
      LED_BREATHE_SLOW: led = now[11] ? now[10:1] : ~now[10:1];
      LED_BREATHE_FAST: led = now[10] ? now[9:0] : ~now[9:0];
      LED_BLINK_FAST,
      LED_BLINK_SLOW:   led = blink ? LED_BLINK_LEVEL : '0;
      default:          led = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/tvac_core.sv
// input register, valve state machine and result register
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tvac_core
  import tvac_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  tvac_in_if.sink    in_ch,
  tvac_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_PREBOOT = 3'd0,
    ST_BOOT    = 3'd1,
    ST_SETUP   = 3'd2,
    ST_OPENING = 3'd3,
    ST_OPENED  = 3'd4,
    ST_CLOSING = 3'd5,
    ST_CLOSED  = 3'd6
  } state_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_OPEN  = 2'd1,
    PEND_CLOSE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        close_pressed;
    logic        open_pressed;
    logic        remote_open;
    logic        remote_close;
  } in_item_t;

  typedef struct packed {
    logic       open_relay;
    logic       close_relay;
    logic [9:0] led_level;
    logic       status_indicator;
    logic       open_indicator;
    logic       close_indicator;
    logic       setup_request;
    logic [2:0] valve_state;
  } out_item_t;

  // handshake and pipeline registers
  logic      s1_valid_r;
  in_item_t  s1_r;
  logic      out_valid_r;
  out_item_t out_r;
  logic      in_fire;
  logic      step;

  // machine state
  state_t     state_r,   state_nxt;
  time_t      phase_r,   phase_nxt;
  cmd_t       pend_r,    pend_nxt;
  logic [9:0] led_r,     led_nxt;
  logic       status_r,  status_nxt;
  logic       olamp_r,   olamp_nxt;
  logic       clamp_r,   clamp_nxt;
  logic       orelay,    crelay;

  time_t      now_t;
  time_t      elapsed;
  led_mode_t  led_mode;
  logic [9:0] led_pat;

  // one word per cycle when the result slot is free or being taken
  assign step        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_valid_r || step);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign now_t   = TIME_WIDTH'(s1_r.now_ms);
  assign elapsed = now_t - phase_r;

  tvac_led u_led (
    .now  (32'(now_t)),
    .mode (led_mode),
    .led  (led_pat)
  );

  // led pattern follows the current state
  always_comb begin
    case (state_r)
      ST_OPENED:  led_mode = LED_BREATHE_SLOW;
      ST_CLOSED:  led_mode = LED_BREATHE_FAST;
      ST_CLOSING: led_mode = LED_BLINK_SLOW;
      default:    led_mode = LED_BLINK_FAST;
    endcase
  end

  // next state for the word in the input register
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    led_nxt    = led_r;
    status_nxt = status_r;
    olamp_nxt  = olamp_r;
    clamp_nxt  = clamp_r;
    orelay     = 1'b0;
    crelay     = 1'b0;

    unique case (state_r)
      ST_PREBOOT: begin
        if (elapsed >= TIME_WIDTH'(cfg.preboot_wait_ms)) begin
          phase_nxt = now_t;
          state_nxt = ST_BOOT;
        end
      end
      ST_BOOT: begin
        // close run after boot counts from the start of boot
        if (s1_r.close_pressed) begin
          if (elapsed >= TIME_WIDTH'(cfg.boot_hold_ms)) begin
            state_nxt = ST_SETUP;
          end
        end else begin
          state_nxt  = ST_CLOSING;
          status_nxt = 1'b1;
        end
        led_nxt = LED_BOOT_LEVEL;
      end
      ST_SETUP: ;
      ST_OPENED: begin
        if (s1_r.close_pressed || pend_r == PEND_CLOSE) begin
          pend_nxt  = PEND_NONE;
          phase_nxt = now_t;
          state_nxt = ST_CLOSING;
          clamp_nxt = 1'b1;
        end
        led_nxt = led_pat;
      end
      ST_CLOSED: begin
        if (s1_r.open_pressed || pend_r == PEND_OPEN) begin
          pend_nxt  = PEND_NONE;
          phase_nxt = now_t;
          state_nxt = ST_OPENING;
          olamp_nxt = 1'b1;
        end
        led_nxt = led_pat;
      end
      ST_OPENING: begin
        if (elapsed >= TIME_WIDTH'(cfg.relay_run_ms)) begin
          state_nxt = ST_OPENED;
          olamp_nxt = 1'b0;
        end else begin
          orelay = 1'b1;
        end
        led_nxt = led_pat;
      end
      ST_CLOSING: begin
        if (elapsed >= TIME_WIDTH'(cfg.relay_run_ms)) begin
          state_nxt = ST_CLOSED;
          clamp_nxt = 1'b0;
        end else begin
          crelay = 1'b1;
        end
        led_nxt = led_pat;
      end
      default: ;
    endcase

    // remote requests only latch in the matching rest state
    if (s1_r.remote_open && state_nxt == ST_CLOSED) begin
      pend_nxt = PEND_OPEN;
    end
    if (s1_r.remote_close && state_nxt == ST_OPENED) begin
      pend_nxt = PEND_CLOSE;
    end
  end

  // state, handshake flags, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_PREBOOT;
      phase_r     <= '0;
      pend_r      <= PEND_NONE;
      led_r       <= '0;
      status_r    <= 1'b0;
      olamp_r     <= 1'b0;
      clamp_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (step) begin
        state_r  <= state_nxt;
        phase_r  <= phase_nxt;
        pend_r   <= pend_nxt;
        led_r    <= led_nxt;
        status_r <= status_nxt;
        olamp_r  <= olamp_nxt;
        clamp_r  <= clamp_nxt;
      end
      if (in_fire) begin
        s1_r.now_ms        <= in_ch.now_ms;
        s1_r.close_pressed <= in_ch.close_pressed;
        s1_r.open_pressed  <= in_ch.open_pressed;
        s1_r.remote_open   <= in_ch.remote_open;
        s1_r.remote_close  <= in_ch.remote_close;
      end
      if (step) begin
        out_r.open_relay       <= orelay;
        out_r.close_relay      <= crelay;
        out_r.led_level        <= led_nxt;
        out_r.status_indicator <= status_nxt;
        out_r.open_indicator   <= olamp_nxt;
        out_r.close_indicator  <= clamp_nxt;
        out_r.setup_request    <= (state_nxt == ST_SETUP);
        out_r.valve_state      <= 3'(state_nxt);
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.open_relay       = out_r.open_relay;
  assign out_ch.close_relay      = out_r.close_relay;
  assign out_ch.led_level        = out_r.led_level;
  assign out_ch.status_indicator = out_r.status_indicator;
  assign out_ch.open_indicator   = out_r.open_indicator;
  assign out_ch.close_indicator  = out_r.close_indicator;
  assign out_ch.setup_request    = out_r.setup_request;
  assign out_ch.valve_state      = out_r.valve_state;

  // setup is left only by reset
  `ASSERT_NEXT(a_setup_sticky, clk, rst_n, state_r == ST_SETUP,
               state_r == ST_SETUP, "setup left without reset")
  // relays are never driven together
  `ASSERT_IMPLY(a_relay_excl, clk, rst_n, out_valid_r,
                !(out_r.open_relay && out_r.close_relay), "both relays driven")
  // open relay only while the reported state is opening
  `ASSERT_IMPLY(a_open_relay_state, clk, rst_n, out_valid_r && out_r.open_relay,
                out_r.valve_state == 3'(ST_OPENING), "open relay outside opening")
  // a stalled input register only comes from a held result
  `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ch.ready,
                s1_valid_r && out_valid_r && !out_ch.ready, "input stalled without backpressure")
  // unused command code never stored
  `ASSERT_ALWAYS(a_pend_code, clk, rst_n,
                 pend_r == PEND_NONE || pend_r == PEND_OPEN || pend_r == PEND_CLOSE,
                 "bad pending command")

endmodule

`default_nettype wire

>>> src/timed_valve_actuator_controller.sv
// A word accepted into the input register moves into the result register when the result slot
// is free or being taken. Throughput is one word per cycle while results are taken,
// set by the single state update between the two registers.
// Input ready drops only while the result register holds an untaken word and the input is full.
// Reset: rst_n is synchronous, active low; it restores registers and the pre-boot state at once,
// with no clearing pass, holds ready low, and words are accepted from the first cycle after it.
`timescale 1ns / 1ps
`default_nettype none

module timed_valve_actuator_controller
  import tvac_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tvac_in_if.sink                    in_ch,
  tvac_out_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t cfg;

  // configuration registers
  tvac_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // valve controller datapath
  tvac_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
